>>> rtl/core/sorted_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Sorted list insert/delete assertion macros
// Concurrent assertion helpers shared by the sorted list RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SLI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list package
// Sizes, command codes and status codes of the sorted list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sli_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

>>> rtl/core/sli_cmp.sv
// ----------------------------------------------------------------------------
// Sorted list compare unit
// Shared comparator: equality for delete, signed greater-or-equal otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sli_cmp
    import sli_pkg::*;
(
    input  logic [DATA_W-1:0] i_entry,
    input  logic [DATA_W-1:0] i_key,
    input  t_cmd              i_cmd,
    output logic              o_hit
);

    always_comb begin
        unique case (i_cmd)
            CMD_DELETE: o_hit = (i_entry == i_key);
            CMD_APPEND,
            CMD_INSERT,
            CMD_DUMP:   o_hit = ($signed(i_entry) >= $signed(i_key));
        endcase
    end

endmodule

>>> rtl/core/sorted_list_insert_delete.sv
// Append and full or empty answers go straight to the result state, then to the result register.
// Insert and delete scan the table with one compare unit, reading and evaluating each stored entry in turn.
// Dump streams the entries one at a time; each read entry is held until the output side is free.
// Throughput is bounded by the single-port table read and the shared comparator.
// Reset (synchronous, active low) empties the list and clears control state;
// the table contents stay undefined until written.
// ----------------------------------------------------------------------------
// Sorted list insert/delete
// Ordered table of signed values with append, insert, delete and dump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_list_insert_delete_macros.svh"

module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_value_res,
    output logic [1:0]        o_status,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [DATA_W-1:0] r_carry, n_carry;
    t_status           r_status, n_status;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    t_status           r_o_status;
    logic              r_o_last;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic              load_out;
    logic [DATA_W-1:0] out_value;
    t_status           out_status;
    logic              out_last;
    logic              out_free;
    logic              full;
    logic              w_hit;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;

    sli_cmp u_cmp (
        .i_entry (r_rdata),
        .i_key   (r_value),
        .i_cmd   (r_cmd),
        .o_hit   (w_hit)
    );

    assign out_free = !r_o_valid || i_ready;
    assign full     = (r_count == CNT_W'(DEPTH));
    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_dec  = r_idx - CNT_W'(1);
    assign o_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_count    = r_count;
        n_idx      = r_idx;
        n_found    = r_found;
        n_carry    = r_carry;
        n_status   = r_status;
        mem_we     = 1'b0;
        mem_waddr  = r_idx[IDX_W-1:0];
        mem_wdata  = r_carry;
        mem_re     = 1'b0;
        load_out   = 1'b0;
        out_value  = '0;
        out_status = ST_OK;
        out_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = t_cmd'(i_command);
                    n_value = i_value;
                    n_idx   = '0;
                    n_found = 1'b0;
                    unique case (t_cmd'(i_command))
                        CMD_APPEND: begin
                            n_state = S_RES;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[IDX_W-1:0];
                                mem_wdata = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_status  = ST_OK;
                            end
                        end
                        CMD_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        CMD_DELETE: begin
                            n_state = S_RD;
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_cmd != CMD_DUMP && r_idx == r_count) begin
                    // The scan ran past the tail: finish the insert or delete.
                    n_state = S_RES;
                    if (r_cmd == CMD_INSERT) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_found ? r_carry : r_value;
                        n_count   = r_count + CNT_W'(1);
                        n_status  = ST_OK;
                    end else if (r_found) begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_EV;
                end
            end
            S_EV: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        // After the insert point, each entry moves up by one slot.
                        if (r_found) begin
                            mem_we  = 1'b1;
                            n_carry = r_rdata;
                        end else if (w_hit) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_value;
                            n_carry   = r_rdata;
                            n_found   = 1'b1;
                        end
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end
                    CMD_DELETE: begin
                        // After the match, each entry moves down by one slot.
                        if (r_found) begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_dec[IDX_W-1:0];
                            mem_wdata = r_rdata;
                        end else if (w_hit) begin
                            n_found = 1'b1;
                        end
                        n_idx   = idx_inc;
                        n_state = S_RD;
                    end
                    CMD_DUMP: begin
                        if (out_free) begin
                            load_out  = 1'b1;
                            out_value = r_rdata;
                            out_last  = (idx_inc == r_count);
                            n_idx     = idx_inc;
                            if (idx_inc == r_count) begin
                                n_count = '0;
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    end
                    CMD_APPEND: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RES: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_status = r_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_found <= n_found;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_carry  <= n_carry;
        r_status <= n_status;
        if (load_out) begin
            r_o_value  <= out_value;
            r_o_status <= out_status;
            r_o_last   <= out_last;
        end
    end

    // Table storage: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_value_res = r_o_value;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

    `SLI_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "entry count exceeds table depth")
    `SLI_ASSERT_IMPL(a_state_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state), "state register is not one-hot")
    `SLI_ASSERT_IMPL(a_ev_in_range, i_clk, i_rst_n, r_state == S_EV, r_idx < r_count, "entry evaluated beyond the list tail")
    `SLI_ASSERT_IMPL(a_found_idx, i_clk, i_rst_n, (r_state == S_RD) && r_found, r_idx != '0, "match flagged before any entry was read")
    `SLI_ASSERT_NEXT(a_dump_clears, i_clk, i_rst_n, (r_state == S_EV) && (r_cmd == CMD_DUMP) && load_out && out_last, (r_count == '0) && r_o_valid && r_o_last, "final dump transfer did not empty the list")

endmodule
